### hw/rtl/rau_pkg.sv
// Package: shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int MAG_W = 64;
    localparam int SH_W = 7;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_ZERODEN = 2'd2;

    typedef struct packed {
        logic       neg;
        logic [OPERAND_WIDTH-1:0] mag;
    } t_op;

    function automatic t_op sext_op(input logic [31:0] v);
        t_op r;
        logic [OPERAND_WIDTH-1:0] m;
        m = v[OPERAND_WIDTH-1:0];
        r.neg = m[OPERAND_WIDTH-1];
        r.mag = r.neg ? (~m + 1'b1) : m;
        return r;
    endfunction
endpackage
`default_nettype wire

### hw/rtl/rau_gcd.sv
// Binary gcd engine: one subtract/shift step per cycle.
`default_nettype none
module rau_gcd import rau_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_x,
    input  wire logic [MAG_W-1:0] i_y,
    output logic                  o_done,
    output logic [MAG_W-1:0]      o_gcd
);
    typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_RUN, S_FIN} t_state;
    t_state r_state;
    logic [MAG_W-1:0] r_x, r_y;
    logic [SH_W-1:0]  r_k;
    logic [MAG_W-1:0] w_diff;

    assign w_diff = (r_x > r_y) ? r_x - r_y : r_y - r_x;

    always_ff @(posedge i_clk) begin
        o_done <= i_rst_n && (r_state == S_FIN);
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_x <= (i_x == '0) ? i_y : i_x;
                    r_y <= i_y; r_k <= '0;
                    r_state <= (i_x == '0) ? S_FIN : S_ALIGN;
                end
                S_ALIGN: begin
                    // strip common factors of two
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1; r_y <= r_y >> 1; r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!r_x[0]) r_x <= r_x >> 1;
                    else if (!r_y[0]) r_y <= r_y >> 1;
                    else if (r_x == r_y) r_state <= S_FIN;
                    else if (r_x > r_y) r_x <= w_diff >> 1;
                    else r_y <= w_diff >> 1;
                end
                S_FIN: begin
                    o_gcd   <= r_x << r_k;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hw/rtl/rau_div.sv
// Restoring divider: one quotient bit per cycle, exact divisions only.
`default_nettype none
module rau_div import rau_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_dividend,
    input  wire logic [MAG_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [MAG_W-1:0]      o_quot
);
    logic             r_busy;
    logic [SH_W-1:0]  r_cnt;
    logic [MAG_W:0]   r_rem;
    logic [MAG_W-1:0] r_q, r_d;
    logic [MAG_W:0]   w_sh;

    assign w_sh = {r_rem[MAG_W-1:0], r_q[MAG_W-1]};

    always_ff @(posedge i_clk) begin
        o_done <= i_rst_n && !i_start && r_busy && (r_cnt == SH_W'(MAG_W - 1));
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= '0; r_rem <= '0;
            r_q <= i_dividend; r_d <= i_divisor;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                r_rem <= w_sh - {1'b0, r_d};
                r_q   <= {r_q[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[MAG_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == SH_W'(MAG_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end
    assign o_quot = r_q;
endmodule
`default_nettype wire

### hw/rtl/rational_arith_unit_top.sv
// Top level: rational arithmetic with gcd reduction.
// One request at a time: a new request is accepted only when idle with no result waiting.
// Run time is set by the binary gcd loop plus two
// passes of the shared bit-serial divider.
// Error requests (zero denominator, divide by zero) give their result in the cycle after acceptance.
// Reset: synchronous active low; clears the sequencer and output valid.
`default_nettype none
module rational_arith_unit_top import rau_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_res_num,
    output logic [61:0]      o_res_den,
    output logic [1:0]       o_status
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT
    } t_state;
    t_state r_state;

    t_op an, ad, bn, bd;
    assign an = sext_op(i_a_num);
    assign ad = sext_op(i_a_den);
    assign bn = sext_op(i_b_num);
    assign bd = sext_op(i_b_den);

    // operand pairs held through the multiply steps
    logic [1:0]  r_cmd;
    t_op         r_an, r_ad, r_bn, r_bd;
    logic [63:0] r_p1, r_p2, r_pd;   // products, one per cycle
    logic [1:0]  r_mstep;
    logic        r_nneg, r_dneg, r_p1n, r_p2n;
    logic [63:0] r_nmag, r_dmag, r_g, r_q;

    // shared multiplier: 32x32 sign-magnitude
    t_op   w_mx, w_my;
    logic [63:0] w_prod;
    always_comb begin
        w_mx = r_an; w_my = r_bd;
        case (r_mstep)
            2'd0: begin
                w_mx = r_an;
                w_my = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            2'd1: begin w_mx = r_bn; w_my = r_ad; end
            default: begin
                w_mx = r_ad;
                w_my = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
        endcase
    end
    assign w_prod = 64'(w_mx.mag) * 64'(w_my.mag);
    logic w_pneg;
    assign w_pneg = w_mx.neg ^ w_my.neg;

    // gcd and divider
    logic g_start, g_done, d_start, d_done;
    logic [63:0] g_out, d_quot, d_dividend;
    logic [63:0] w_nsel;             // numerator magnitude formed in S_SUM
    rau_gcd u_gcd (.i_clk, .i_rst_n, .i_start(g_start), .i_x(w_nsel),
                   .i_y(r_pd), .o_done(g_done), .o_gcd(g_out));
    assign d_dividend = (r_state == S_GCD) ? r_nmag : r_dmag;
    rau_div u_div (.i_clk, .i_rst_n, .i_start(d_start), .i_dividend(d_dividend),
                   .i_divisor(g_done ? g_out : r_g), .o_done(d_done),
                   .o_quot(d_quot));

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign g_start = (r_state == S_SUM);
    assign d_start = (r_state == S_GCD && g_done) || (r_state == S_DIVN && d_done);

    // signed sum of the two cross products
    logic        w_bneg;
    logic [63:0] w_smag;
    logic        w_sneg;
    always_comb begin
        w_bneg = r_p2n ^ (r_cmd == CMD_SUB);
        if (r_p1n == w_bneg) begin
            w_smag = r_p1 + r_p2; w_sneg = r_p1n;
        end else if (r_p1 >= r_p2) begin
            w_smag = r_p1 - r_p2; w_sneg = r_p1n;
        end else begin
            w_smag = r_p2 - r_p1; w_sneg = w_bneg;
        end
    end
    assign w_nsel = (r_cmd == CMD_ADD || r_cmd == CMD_SUB) ? w_smag : r_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_cmd <= i_command;
                    r_an <= an; r_ad <= ad; r_bn <= bn; r_bd <= bd;
                    r_mstep <= 2'd0;
                    if (ad.mag == '0 || bd.mag == '0) begin
                        o_res_num <= '0; o_res_den <= 62'd1;
                        o_status <= ST_ZERODEN; o_valid <= 1'b1;
                    end else if (i_command == CMD_DIV && bn.mag == '0) begin
                        o_res_num <= '0; o_res_den <= 62'd1;
                        o_status <= ST_DIV0; o_valid <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_mstep)
                        2'd0: begin r_p1 <= w_prod; r_p1n <= w_pneg; end
                        2'd1: begin r_p2 <= w_prod; r_p2n <= w_pneg; end
                        default: begin r_pd <= w_prod; r_dneg <= w_pneg; end
                    endcase
                    // multiply and divide need no second cross product
                    r_mstep <= (r_mstep == 2'd0 && (r_cmd == CMD_MUL || r_cmd == CMD_DIV))
                               ? 2'd2 : r_mstep + 1'b1;
                    if (r_mstep == 2'd2) r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_nneg <= w_sneg;
                    end else begin
                        r_nneg <= r_p1n;
                    end
                    r_nmag  <= w_nsel;
                    r_dmag  <= r_pd;
                    r_state <= S_GCD;
                end
                S_GCD: if (g_done) begin
                    r_g <= g_out; r_state <= S_DIVN;
                end
                S_DIVN: if (d_done) begin
                    r_q <= d_quot; r_state <= S_DIVD;
                end
                S_DIVD: if (d_done) begin
                    o_res_num <= (r_q != '0 && (r_nneg ^ r_dneg)) ? (~r_q + 1'b1) : r_q;
                    o_res_den <= d_quot[61:0];
                    o_status  <= ST_OK;
                    r_state   <= S_OUT;
                end
                S_OUT: if (!o_valid) begin
                    o_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_SUM hands the freshly formed magnitudes straight to the gcd engine,
    // so the gcd starts at the same edge that registers them.
    ap_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_DIV0 || o_status == ST_ZERODEN))
        else $error("bad status");
    ap_noaccept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    ap_errden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_res_num == '0 && o_res_den == 62'd1))
        else $error("error result not 0/1");
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the rational arithmetic unit top level.
`default_nettype none
module tb_top;
    import rau_pkg::*;

    // Request fields and result fields as the bench holds them
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] an, ad, bn, bd;
    } t_req;

    typedef struct packed {
        logic [63:0] num;
        logic [61:0] den;
        logic [1:0]  st;
    } t_res;

    // Directed row: request plus optional hand-written answer
    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    localparam int N_RANDOM   = 1850;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_ADD;
    logic [31:0] i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_res_num;
    logic [61:0] o_res_den;
    logic [1:0]  o_status;

    rational_arith_unit_top i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command,
        .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_valid, .i_ready, .o_res_num, .o_res_den, .o_status
    );

    always #6 i_clk = ~i_clk;

    t_res        pending_results[$];
    int          n_fail = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_err  = 0;
    int          idle_tx = 0;   // sender idle percentage
    int          idle_rx = 0;   // receiver stall percentage
    int          quiet = 0;
    bit          tx_done = 1'b0;
    t_row        rows[$];

    // Operand as sign and magnitude (magnitude up to 2^31)
    function automatic void split_op(input logic [31:0] v, output bit neg,
                                     output logic [63:0] mag);
        neg = v[31];
        mag = neg ? {32'd0, ~v + 32'd1} : {32'd0, v};
        if (neg && v == 32'h8000_0000)
            mag = 64'h8000_0000;
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact fraction result of one request
    function automatic t_res fraction_result(input t_req r);
        t_res o;
        bit na, nad, nb, nbd, s1, s2, nn, dn, neg;
        logic [63:0] ma, mad, mb, mbd, p1, p2, nm, dm, g;
        split_op(r.an, na, ma);
        split_op(r.ad, nad, mad);
        split_op(r.bn, nb, mb);
        split_op(r.bd, nbd, mbd);
        o.num = 64'd0; o.den = 62'd1;
        if (mad == 0 || mbd == 0) begin
            o.st = ST_ZERODEN;
            return o;
        end
        if (r.cmd == CMD_DIV && mb == 0) begin
            o.st = ST_DIV0;
            return o;
        end
        o.st = ST_OK;
        case (r.cmd)
            CMD_ADD, CMD_SUB: begin
                p1 = ma * mbd; s1 = (p1 != 0) && (na != nbd);
                p2 = mb * mad; s2 = (p2 != 0) && (nb != nad);
                if (r.cmd == CMD_SUB && p2 != 0) s2 = ~s2;
                if (s1 == s2) begin
                    nm = p1 + p2; nn = s1;
                end else if (p1 >= p2) begin
                    nm = p1 - p2; nn = s1;
                end else begin
                    nm = p2 - p1; nn = s2;
                end
                dm = mad * mbd; dn = nad != nbd;
            end
            CMD_MUL: begin
                nm = ma * mb; nn = na != nb;
                dm = mad * mbd; dn = nad != nbd;
            end
            default: begin
                nm = ma * mbd; nn = na != nbd;
                dm = mad * mb; dn = nad != nb;
            end
        endcase
        if (nm == 0) nn = 1'b0;
        g = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        neg = (nm != 0) && (nn != dn);
        o.num = neg ? -nm : nm;
        o.den = dm[61:0];
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001;
            2: return 32'h8000_0000;
            3, 4: return $signed($urandom_range(0, 40)) - 20;
            5: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row mk_row(input logic [1:0] c, input logic [31:0] an,
            input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd,
            input bit known, input logic [63:0] n, input logic [61:0] d,
            input logic [1:0] s);
        t_row w;
        w.req = '{c, an, ad, bn, bd};
        w.known = known;
        w.res = '{n, d, s};
        return w;
    endfunction

    // Drive one request at the falling edge and hold until taken;
    // valid drops only while the sender idles
    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < idle_tx) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_command <= r.cmd;
        i_a_num <= r.an; i_a_den <= r.ad;
        i_b_num <= r.bn; i_b_den <= r.bd;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Expected results are queued at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            pending_results.push_back(fraction_result('{i_command, i_a_num,
                i_a_den, i_b_num, i_b_den}));
            n_sent++;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            n_recv++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result num=%h den=%h st=%0d", $time,
                         o_res_num, o_res_den, o_status);
                n_fail++;
            end else begin
                e = pending_results.pop_front();
                if (e.st != ST_OK) n_err++;
                if (o_res_num !== e.num || o_res_den !== e.den || o_status !== e.st) begin
                    $display("%0t: expected num=%h den=%h st=%0d, got num=%h den=%h st=%0d",
                             $time, e.num, e.den, e.st, o_res_num, o_res_den, o_status);
                    n_fail++;
                end
            end
        end
    end

    // Receiver stalls at random
    always @(negedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= idle_rx);

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet <= 0;
        else if (quiet + 1 >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("rational_arith_unit_top: mismatch");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    initial begin
        t_req r;
        int ph;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed answers only where obvious
        rows.push_back(mk_row(CMD_ADD, 1, 0, 1, 1, 1, 0, 1, ST_ZERODEN));
        rows.push_back(mk_row(CMD_DIV, 1, 1, 0, 0, 1, 0, 1, ST_ZERODEN));
        rows.push_back(mk_row(CMD_DIV, 5, 3, 0, 7, 1, 0, 1, ST_DIV0));
        rows.push_back(mk_row(CMD_MUL, 0, 9, 4, 5, 1, 0, 1, ST_OK));
        rows.push_back(mk_row(CMD_SUB, 3, 4, 3, 4, 1, 0, 1, ST_OK));
        rows.push_back(mk_row(CMD_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK));
        rows.push_back(mk_row(CMD_MUL, 2, -4, 3, 9, 1, -1, 6, ST_OK));
        rows.push_back(mk_row(CMD_DIV, 1, 2, -1, 4, 1, -2, 1, ST_OK));
        rows.push_back(mk_row(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h8000_0001, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_MUL, 32'h7fff_ffff, 32'h7ffffffe, 32'h8000_0001,
                              32'h7fff_fffd, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DIV, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffd,
                              32'h8000_0001, 0, 0, 0, 0));
        // most negative operands (wrap cases), then all operands minus one
        rows.push_back(mk_row(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_MUL, 1, 32'h8000_0000, 1, 32'h8000_0000, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 0, 0, 0, 0));
        foreach (rows[k]) begin
            if (rows[k].known && fraction_result(rows[k].req) != rows[k].res) begin
                $display("%0t: table row %0d disagrees with the predictor", $time, k);
                n_fail++;
            end
            send_request(rows[k].req);
        end

        // Random requests in three idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            ph = i * 3 / N_RANDOM;
            idle_tx = (ph == 0) ? 23 : (ph == 1) ? 70 : 0;
            idle_rx = (ph == 0) ? 70 : (ph == 1) ? 23 : 0;
            r.cmd = $urandom_range(0, 3);
            r.an = rand_operand(); r.ad = rand_operand();
            r.bn = rand_operand(); r.bd = rand_operand();
            if ($urandom_range(0, 9) != 0) begin
                if (r.ad == 0) r.ad = 32'd1;
                if (r.bd == 0) r.bd = 32'hffff_ffff;
            end
            send_request(r);
        end
        i_valid <= 1'b0;
        tx_done = 1'b1;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Requests sent %0d, results checked %0d, error-status results %0d.",
                 n_sent, n_recv, n_err);
        $display("Covered all four operations, zero denominators, divide by zero and"
                 , " extreme operands under three stall patterns.");
        if (n_fail == 0 && pending_results.size() == 0)
            $display("rational_arith_unit_top: match");
        else
            $display("rational_arith_unit_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
